// File: rtl/core/mpma_pkg.sv
// Package for the mirror padded moving average block.
// Shared constants, controller/datapath command and status structs.
`timescale 1ns / 1ps
`default_nettype none
package mpma_pkg;
    localparam int MAX_HALF_WINDOW = 31;
    localparam int SAMPLE_BITS     = 16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_WIDE  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    localparam logic CFG_WINDOW_LEN = 1'b0;
    localparam logic CFG_PAD_WIDTH  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic store;      // write sample into ring, advance pointer
        logic clr_acc;    // start a new window sum
        logic acc;        // add one tap (read data valid)
        logic div_start;  // begin the division
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
    } t_sts;
endpackage
`default_nettype wire

// File: rtl/core/mpma_datapath.sv
// Datapath: sample ring memory, tap accumulator and restoring divider.
// Depends on mpma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpma_datapath #(
    parameter int HALF_MAX = mpma_pkg::MAX_HALF_WINDOW,
    parameter int SBITS    = mpma_pkg::SAMPLE_BITS,
    localparam int DEPTH   = 2 * HALF_MAX + 1,
    localparam int AW      = $clog2(DEPTH),
    localparam int ABITS   = SBITS + AW + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mpma_pkg::t_cmd     i_cmd,
    output mpma_pkg::t_sts          o_sts,
    input  wire logic [SBITS-1:0]   i_wdata,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [AW-1:0]      i_raddr,
    input  wire logic [5:0]         i_divisor,
    output logic [SBITS-1:0]        o_quot
);
    logic [SBITS-1:0] r_mem [DEPTH];
    logic [SBITS-1:0] r_rdata;
    logic signed [ABITS-1:0] r_acc;
    logic [ABITS-1:0] r_rem, r_q;
    logic [ABITS:0]   r_part;
    logic [$clog2(ABITS+1)-1:0] r_cnt;
    logic r_busy, r_neg, r_done;
    logic [ABITS:0] n_part;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) r_acc <= '0;
        else if (i_cmd.acc)
            r_acc <= r_acc + ABITS'($signed(r_rdata));
    end

    // restoring division of |sum| by k, one quotient bit per cycle
    assign n_part = {r_part[ABITS-1:0], r_rem[ABITS-1]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_neg  <= r_acc[ABITS-1];
                r_rem  <= r_acc[ABITS-1] ? ABITS'(-r_acc) : ABITS'(r_acc);
                r_part <= '0;
                r_q    <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_rem <= {r_rem[ABITS-2:0], 1'b0};
                if (n_part >= (ABITS+1)'(i_divisor)) begin
                    r_part <= n_part - (ABITS+1)'(i_divisor);
                    r_q    <= {r_q[ABITS-2:0], 1'b1};
                end else begin
                    r_part <= n_part;
                    r_q    <= {r_q[ABITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(ABITS+1))'(ABITS-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_neg ? SBITS'(-r_q) : SBITS'(r_q);
    assign o_sts.div_done = r_done;
endmodule
`default_nettype wire

// File: rtl/core/mpma_ctrl.sv
// Controller: block bookkeeping, tap address sequencing, result handshake.
// Depends on mpma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpma_ctrl #(
    parameter int HALF_MAX = mpma_pkg::MAX_HALF_WINDOW,
    parameter int SBITS    = mpma_pkg::SAMPLE_BITS,
    localparam int DEPTH   = 2 * HALF_MAX + 1,
    localparam int AW      = $clog2(DEPTH),
    localparam int JW      = $clog2(DEPTH + 1),
    localparam int DW      = JW + 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [SBITS-1:0] i_sample,
    input  wire logic             i_last_sample,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [SBITS-1:0]      o_mean,
    output logic                  o_out_last,
    output logic [1:0]            o_status,
    input  wire logic [5:0]       i_window_len,
    input  wire logic [4:0]       i_pad_width,
    output mpma_pkg::t_cmd        o_cmd,
    input  wire mpma_pkg::t_sts   i_sts,
    output logic [SBITS-1:0]      o_wdata,
    output logic [AW-1:0]         o_waddr,
    output logic [AW-1:0]         o_raddr,
    output logic [5:0]            o_divisor,
    input  wire logic [SBITS-1:0] i_quot
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_DIV  = 5'b00100,
        S_OUT  = 5'b01000,
        S_NEXT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_ptr, r_newest;
    logic [JW-1:0] r_seen, r_j;
    logic [5:0]    r_k;
    logic [4:0]    r_q;
    logic [5:0]    r_c;        // position offset being worked
    logic [6:0]    r_t;        // tap index 0..2q
    logic          r_rd_pend;  // read issued last cycle
    logic          r_flush;
    logic          r_ov;
    logic [SBITS-1:0] r_mean;
    logic          r_olast;
    logic [1:0]    r_ostat;

    logic [5:0] k_eff;
    logic [4:0] q_now;
    logic       too_wide;
    logic       go_sum;
    logic signed [DW-1:0] d;
    logic [DW-1:0] b;
    logic [AW:0] rsum;
    logic issue;

    assign k_eff    = (i_window_len == 6'd0) ? 6'd1 : i_window_len;
    assign q_now    = 5'((k_eff - 6'd1) >> 1);
    assign too_wide = (q_now > i_pad_width) || (32'(q_now) > HALF_MAX);
    // accepted sample starts a window sum
    assign go_sum   = !too_wide && (i_last_sample ? (32'(r_seen) + 1 >= 32'(q_now))
                                                  : (32'(r_seen) >= 32'(q_now)));

    // mirrored distance back from newest sample for tap r_t
    always_comb begin
        d = DW'(signed'({1'b0, r_c})) - DW'(signed'({1'b0, r_t})) + DW'(signed'({1'b0, r_q}));
        if (d < 0) d = -d - DW'(1);
        else if (d > DW'(signed'({1'b0, r_j}))) d = DW'(2) * DW'(signed'({1'b0, r_j})) - d + DW'(1);
        b = d;
        rsum = {1'b0, r_newest} + AW'(DEPTH) - (AW+1)'(b);
        if (rsum >= (AW+1)'(DEPTH)) rsum = rsum - (AW+1)'(DEPTH);
    end

    assign issue    = (r_state == S_SUM) && (r_t <= {r_q, 1'b0});
    assign o_raddr  = rsum[AW-1:0];
    assign o_wdata  = i_sample;
    assign o_waddr  = r_ptr;
    assign o_divisor = r_k;
    assign o_stall  = (r_state != S_IDLE) || r_ov;
    assign o_valid  = r_ov;
    assign o_mean   = r_mean;
    assign o_out_last = r_olast;
    assign o_status = r_ostat;

    always_comb begin
        o_cmd.store     = (r_state == S_IDLE) && i_valid && !r_ov;
        o_cmd.clr_acc   = (r_state == S_IDLE) || (r_state == S_NEXT);
        o_cmd.acc       = r_rd_pend;
        o_cmd.div_start = (r_state == S_SUM) && !issue && !r_rd_pend;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (o_cmd.store && go_sum) n_state = S_SUM;
            S_SUM:  if (o_cmd.div_start) n_state = S_DIV;
            S_DIV:  if (i_sts.div_done) n_state = S_OUT;
            S_OUT:  if (!r_ov) n_state = (r_flush && r_c != 6'd0) ? S_NEXT : S_IDLE;
            S_NEXT: n_state = S_SUM;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr <= '0;
            r_seen <= '0;
            r_ov <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_pend <= issue;
            if (issue) r_t <= r_t + 7'd1;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (o_cmd.store) begin
                r_newest <= r_ptr;
                r_ptr <= (32'(r_ptr) == DEPTH - 1) ? '0 : r_ptr + AW'(1);
                r_j <= r_seen;
                r_k <= k_eff;
                r_q <= q_now;
                r_t <= '0;
                r_flush <= i_last_sample;
                if (i_last_sample) r_seen <= '0;
                else if (32'(r_seen) < DEPTH) r_seen <= r_seen + JW'(1);
                if (i_last_sample && too_wide) begin
                    r_ov <= 1'b1; r_mean <= '0; r_olast <= 1'b1;
                    r_ostat <= mpma_pkg::ST_WIDE;
                end else if (i_last_sample && (32'(r_seen) + 1 < 32'(q_now))) begin
                    r_ov <= 1'b1; r_mean <= '0; r_olast <= 1'b1;
                    r_ostat <= mpma_pkg::ST_SHORT;
                end else if (i_last_sample) begin
                    r_c <= (32'(r_seen) < 32'(q_now)) ? 6'(r_seen) : 6'(q_now);
                end else if (!too_wide && 32'(r_seen) >= 32'(q_now)) begin
                    r_c <= 6'(q_now);
                end
            end
            if (r_state == S_DIV && i_sts.div_done) begin
                r_ov <= 1'b1;
                r_mean <= i_quot;
                r_olast <= r_flush && (r_c == 6'd0);
                r_ostat <= mpma_pkg::ST_OK;
            end
            if (r_state == S_NEXT) begin
                r_c <= r_c - 6'd1;
                r_t <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/mirror_padded_moving_average.sv
// Top level of the mirror padded moving average block.
// Depends on mpma_pkg, mpma_ctrl and mpma_datapath.
// Channel   | Direction | Handshake        | Payload
// input     | in        | valid / stall    | sample, last_sample
// result    | out       | valid / stall    | mean, out_last, status
// config    | in        | valid / ready    | index, data
// One transaction per sample. Each average runs the tap sum (2q+1 ring reads,
// each accumulated, then one divider start), SAMPLE_BITS+AW+1 divider steps
// and the output handoff. A sample with no average is only stored, and a
// status-only result goes straight to the output handoff.
// Reset is synchronous, active low, and clears control state only; ring is
// undefined until written. Input stalls while a result is in flight or waits.
`timescale 1ns / 1ps
`default_nettype none
module mirror_padded_moving_average #(
    parameter int MAX_HALF_WINDOW = mpma_pkg::MAX_HALF_WINDOW,
    parameter int SAMPLE_BITS     = mpma_pkg::SAMPLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_last_sample,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [SAMPLE_BITS-1:0]      o_mean,
    output logic                        o_out_last,
    output logic [1:0]                  o_status,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic                   i_cfg_index,
    input  wire logic [5:0]             i_cfg_data
);
    localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [5:0] r_window_len;
    logic [4:0] r_pad_width;
    mpma_pkg::t_cmd cmd;
    mpma_pkg::t_sts sts;
    logic [SAMPLE_BITS-1:0] wdata, quot;
    logic [AW-1:0] waddr, raddr;
    logic [5:0] divisor;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= 6'd3;
            r_pad_width  <= 5'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mpma_pkg::CFG_WINDOW_LEN: r_window_len <= i_cfg_data;
                mpma_pkg::CFG_PAD_WIDTH:  r_pad_width  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    mpma_ctrl #(.HALF_MAX(MAX_HALF_WINDOW), .SBITS(SAMPLE_BITS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_sample, .i_last_sample,
        .o_valid, .i_stall, .o_mean, .o_out_last, .o_status,
        .i_window_len(r_window_len), .i_pad_width(r_pad_width),
        .o_cmd(cmd), .i_sts(sts), .o_wdata(wdata), .o_waddr(waddr),
        .o_raddr(raddr), .o_divisor(divisor), .i_quot(quot)
    );

    mpma_datapath #(.HALF_MAX(MAX_HALF_WINDOW), .SBITS(SAMPLE_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts), .i_wdata(wdata),
        .i_waddr(waddr), .i_raddr(raddr), .i_divisor(divisor), .o_quot(quot)
    );
endmodule
`default_nettype wire
